// ===== rtl/tcce_pkg.sv =====
// tcce_pkg: shared codes, control word layout and microcode rom for the text cursor engine
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  // fixed geometry of the glyph cells and the frame buffer
  localparam int GLYPH_WIDTH     = 8;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int TAB_STOP        = 8;   // power of two, the column mask in the core relies on it
  localparam int MAX_RESULTS     = 8;

  // field widths
  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int GH_W     = 6;
  localparam int COLOR_W  = 32;
  localparam int REGION_W = 25;
  localparam int CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int TAB_W    = $clog2(TAB_STOP);
  localparam int GHC_W    = GH_W + COL_W;                               // glyph_height*columns
  localparam int RB_W     = GHC_W + $clog2(GLYPH_WIDTH * BYTES_PER_PIXEL); // row bytes
  localparam int PROD_W   = RB_W + ROW_W + 1;
  localparam logic [PROD_W-1:0] REGION_CAP = PROD_W'(24'hFF_FFFF) + PROD_W'(1);

  // characters with a meaning of their own
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // input opcodes
  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_BACK    = 3'd1;
  localparam logic [2:0] OP_NEWLINE = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_REFRESH = 3'd4;

  // output commands
  localparam logic [2:0] CMD_DRAW         = 3'd0;
  localparam logic [2:0] CMD_CLEAR_CELL   = 3'd1;
  localparam logic [2:0] CMD_SCROLL       = 3'd2;
  localparam logic [2:0] CMD_CLEAR_SCREEN = 3'd3;
  localparam logic [2:0] CMD_FLUSH        = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_COLUMNS    = 3'd0;
  localparam logic [2:0] REG_ROWS       = 3'd1;
  localparam logic [2:0] REG_GLYPH_H    = 3'd2;
  localparam logic [2:0] REG_DEFAULT_FG = 3'd3;
  localparam logic [2:0] REG_BACKGROUND = 3'd4;
  localparam logic [2:0] REG_BOLD       = 3'd5;
  localparam logic [2:0] REG_RENDER     = 3'd6;

  // datapath action of one microstep
  typedef enum logic [3:0] {
    A_WAIT,
    A_NOP,
    A_WRAP,
    A_SCROLL_CHK,
    A_EMIT_DRAW,
    A_LINE_FEED,
    A_EMIT_SCROLL,
    A_BACKSPACE,
    A_EMIT_CLR_CELL,
    A_CLEAR,
    A_EMIT_CLS,
    A_ROW_BYTES,
    A_REGION_START,
    A_REGION_END,
    A_EMIT_FLUSH
  } action_t;

  // sequencing condition of one microstep
  typedef enum logic [2:0] {
    C_DISPATCH,   // wait for a transaction, then jump through the map
    C_NEXT,       // fall through
    C_ALWAYS,     // jump to target
    C_LAST,       // jump when the final glyph went out
    C_BS_ORIGIN,  // jump when the cursor sits at the origin
    C_NO_FLUSH    // jump when the flushed cursor equals the cursor
  } cond_t;

  localparam int UPC_W = 4;

  typedef struct packed {
    action_t          act;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  // microprogram entry points
  localparam logic [UPC_W-1:0] UPC_IDLE    = 4'd0;
  localparam logic [UPC_W-1:0] UPC_PUT     = 4'd1;
  localparam logic [UPC_W-1:0] UPC_LF      = 4'd5;
  localparam logic [UPC_W-1:0] UPC_BACK    = 4'd8;
  localparam logic [UPC_W-1:0] UPC_CLEAR   = 4'd10;
  localparam logic [UPC_W-1:0] UPC_REFRESH = 4'd12;

  // control store
  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_word_t cw;
    case (upc)
      4'd0:    cw = '{A_WAIT,          C_DISPATCH,  UPC_IDLE};
      4'd1:    cw = '{A_WRAP,          C_NEXT,      UPC_IDLE};
      4'd2:    cw = '{A_SCROLL_CHK,    C_NEXT,      UPC_IDLE};
      4'd3:    cw = '{A_EMIT_DRAW,     C_LAST,      UPC_IDLE};
      4'd4:    cw = '{A_NOP,           C_ALWAYS,    UPC_PUT};
      4'd5:    cw = '{A_LINE_FEED,     C_NEXT,      UPC_IDLE};
      4'd6:    cw = '{A_SCROLL_CHK,    C_NEXT,      UPC_IDLE};
      4'd7:    cw = '{A_EMIT_SCROLL,   C_ALWAYS,    UPC_IDLE};
      4'd8:    cw = '{A_BACKSPACE,     C_BS_ORIGIN, UPC_IDLE};
      4'd9:    cw = '{A_EMIT_CLR_CELL, C_ALWAYS,    UPC_IDLE};
      4'd10:   cw = '{A_CLEAR,         C_NEXT,      UPC_IDLE};
      4'd11:   cw = '{A_EMIT_CLS,      C_ALWAYS,    UPC_IDLE};
      4'd12:   cw = '{A_ROW_BYTES,     C_NO_FLUSH,  UPC_IDLE};
      4'd13:   cw = '{A_REGION_START,  C_NEXT,      UPC_IDLE};
      4'd14:   cw = '{A_REGION_END,    C_NEXT,      UPC_IDLE};
      4'd15:   cw = '{A_EMIT_FLUSH,    C_ALWAYS,    UPC_IDLE};
      default: cw = '{A_NOP,           C_ALWAYS,    UPC_IDLE};
    endcase
    return cw;
  endfunction

  // dispatch map from the accepted operation to its routine
  function automatic logic [UPC_W-1:0] ucode_map(input logic [2:0] op, input logic [7:0] ch);
    logic [UPC_W-1:0] entry;
    case (op)
      OP_PUT:     entry = (ch == CHAR_LF) ? UPC_LF : UPC_PUT;
      OP_BACK:    entry = UPC_BACK;
      OP_NEWLINE: entry = UPC_LF;
      OP_CLEAR:   entry = UPC_CLEAR;
      OP_REFRESH: entry = UPC_REFRESH;
      default:    entry = UPC_IDLE;   // unused opcodes do nothing
    endcase
    return entry;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_engine_core.sv =====
// text_console_cursor_engine_core: microcoded text cursor engine, top level
//
// Takes one console operation per input transaction (put character, backspace,
// newline, clear, refresh) and issues cell draw, cell clear, scroll, clear-screen
// and flush-region commands on the output channel, the last one of each operation
// flagged. A 16-step microprogram in a read-only control store steps a small
// datapath, one step per clock, and the next transaction is taken only when the
// program is back at its wait step. A tab of n spaces runs the character routine
// n times; a backspace at the origin or a refresh with nothing new issues no
// command, and an unused opcode does nothing. Each command step waits while
// the output register holds a command not yet taken. Refresh runs its row-byte
// products through one 6x9 and one shared 9x20 multiplier over three steps.
// Configuration writes take effect at the clock edge of the write and belong to
// idle periods.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [7:0]  char_code,
  input  wire logic [31:0] draw_color,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       command,
  output logic [7:0]       cell_col,
  output logic [6:0]       cell_row,
  output logic [7:0]       glyph_code,
  output logic [31:0]      fg_out,
  output logic [31:0]      bg_out,
  output logic             bold_out,
  output logic             scroll_before,
  output logic [24:0]      region_start,
  output logic [24:0]      region_end,
  output logic             last
);

  // configuration registers
  logic [tcce_pkg::COL_W-1:0]   text_columns;
  logic [tcce_pkg::ROW_W-1:0]   text_rows;
  logic [tcce_pkg::GH_W-1:0]    glyph_height;
  logic [tcce_pkg::COLOR_W-1:0] default_fg;
  logic [tcce_pkg::COLOR_W-1:0] background;
  logic                         bold_font;
  logic                         render_on;

  // cursor state
  logic [tcce_pkg::COL_W-1:0] cursor_col;
  logic [tcce_pkg::ROW_W-1:0] cursor_row;
  logic [tcce_pkg::COL_W-1:0] flushed_col;
  logic [tcce_pkg::ROW_W-1:0] flushed_row;

  // per-transaction working registers
  logic [7:0]                      char_q;
  logic [tcce_pkg::COLOR_W-1:0]    fg_q;
  logic [tcce_pkg::CNT_W-1:0]      cnt_q;
  logic                            scr_q;
  logic [tcce_pkg::RB_W-1:0]       rb_q;
  logic [tcce_pkg::REGION_W-1:0]   rs_q;
  logic [tcce_pkg::REGION_W-1:0]   re_q;

  // sequencer
  logic [tcce_pkg::UPC_W-1:0] upc;
  logic [tcce_pkg::UPC_W-1:0] upc_next;
  tcce_pkg::ctrl_word_t       cw;

  logic in_accept;
  logic emit_req;
  logic emit_go;
  logic out_load;
  logic stall;
  logic is_last;

  logic [tcce_pkg::GHC_W-1:0]  ghc_prod;
  logic [tcce_pkg::ROW_W:0]    mul_a;
  logic [tcce_pkg::PROD_W-1:0] mul_prod;
  logic [tcce_pkg::REGION_W-1:0] mul_sat;
  logic [tcce_pkg::CNT_W-1:0]  tab_count;

  // next output command
  logic [2:0]                    cmd_d;
  logic [7:0]                    col_d;
  logic [6:0]                    row_d;
  logic [7:0]                    glyph_d;
  logic [31:0]                   fg_d;
  logic [31:0]                   bg_d;
  logic                          bold_d;
  logic                          scr_d;
  logic [24:0]                   rs_d;
  logic [24:0]                   re_d;

  assign cw        = tcce_pkg::ucode_rom(upc);
  assign in_ready  = (cw.act == tcce_pkg::A_WAIT);
  assign in_accept = in_valid && in_ready;
  assign is_last   = (cnt_q == tcce_pkg::CNT_W'(1));

  // spaces up to the next tab stop, never above the result limit
  assign tab_count = tcce_pkg::CNT_W'(tcce_pkg::TAB_STOP)
                   - tcce_pkg::CNT_W'(cursor_col[tcce_pkg::TAB_W-1:0]);

  // command steps and their handshake with the output register
  always_comb begin
    case (cw.act)
      tcce_pkg::A_EMIT_DRAW,
      tcce_pkg::A_EMIT_CLR_CELL,
      tcce_pkg::A_EMIT_CLS,
      tcce_pkg::A_EMIT_FLUSH:  emit_req = 1'b1;
      tcce_pkg::A_EMIT_SCROLL: emit_req = scr_q;
      default:                 emit_req = 1'b0;
    endcase
  end

  assign emit_go  = !render_on || !out_valid || out_ready;
  assign stall    = emit_req && !emit_go;
  assign out_load = emit_req && render_on && emit_go;

  // shared region multiplier with saturation
  always_comb begin
    if (cw.act == tcce_pkg::A_REGION_END) begin
      mul_a = {1'b0, cursor_row} + (tcce_pkg::ROW_W + 1)'(1);
    end else begin
      mul_a = {1'b0, flushed_row};
    end
    mul_prod = tcce_pkg::PROD_W'(mul_a) * tcce_pkg::PROD_W'(rb_q);
    if (mul_prod > tcce_pkg::REGION_CAP) begin
      mul_sat = tcce_pkg::REGION_CAP[tcce_pkg::REGION_W-1:0];
    end else begin
      mul_sat = mul_prod[tcce_pkg::REGION_W-1:0];
    end
  end

  assign ghc_prod = tcce_pkg::GHC_W'(glyph_height) * tcce_pkg::GHC_W'(text_columns);

  // microprogram sequencing
  always_comb begin
    upc_next = upc + tcce_pkg::UPC_W'(1);
    case (cw.cond)
      tcce_pkg::C_DISPATCH:  upc_next = in_accept ? tcce_pkg::ucode_map(opcode, char_code) : upc;
      tcce_pkg::C_NEXT:      upc_next = upc + tcce_pkg::UPC_W'(1);
      tcce_pkg::C_ALWAYS:    upc_next = cw.target;
      tcce_pkg::C_LAST:      if (is_last) upc_next = cw.target;
      tcce_pkg::C_BS_ORIGIN: if (cursor_col == '0 && cursor_row == '0) upc_next = cw.target;
      tcce_pkg::C_NO_FLUSH: begin
        if (flushed_col == cursor_col && flushed_row == cursor_row) upc_next = cw.target;
      end
      default:               upc_next = tcce_pkg::UPC_IDLE;
    endcase
    if (stall) upc_next = upc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= tcce_pkg::UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= 9'd128;
      text_rows    <= 8'd48;
      glyph_height <= 6'd16;
      default_fg   <= 32'h00FF_FFFF;
      background   <= 32'h0;
      bold_font    <= 1'b0;
      render_on    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tcce_pkg::REG_COLUMNS:    text_columns <= cfg_data[tcce_pkg::COL_W-1:0];
        tcce_pkg::REG_ROWS:       text_rows    <= cfg_data[tcce_pkg::ROW_W-1:0];
        tcce_pkg::REG_GLYPH_H:    glyph_height <= cfg_data[tcce_pkg::GH_W-1:0];
        tcce_pkg::REG_DEFAULT_FG: default_fg   <= cfg_data;
        tcce_pkg::REG_BACKGROUND: background   <= cfg_data;
        tcce_pkg::REG_BOLD:       bold_font    <= cfg_data[0];
        tcce_pkg::REG_RENDER:     render_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // cursor datapath, driven by the current action
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col  <= '0;
      cursor_row  <= '0;
      flushed_col <= '0;
      flushed_row <= '0;
    end else begin
      case (cw.act)
        tcce_pkg::A_WRAP: begin
          if (cursor_col >= text_columns) begin
            cursor_col <= '0;
            cursor_row <= cursor_row + tcce_pkg::ROW_W'(1);
          end
        end
        tcce_pkg::A_SCROLL_CHK: begin
          if (cursor_row >= text_rows) begin
            flushed_col <= '0;
            flushed_row <= '0;
            cursor_col  <= '0;
            cursor_row  <= cursor_row - tcce_pkg::ROW_W'(1);
          end
        end
        tcce_pkg::A_EMIT_DRAW: begin
          if (!stall) cursor_col <= cursor_col + tcce_pkg::COL_W'(1);
        end
        tcce_pkg::A_LINE_FEED: begin
          cursor_col <= '0;
          cursor_row <= cursor_row + tcce_pkg::ROW_W'(1);
        end
        tcce_pkg::A_BACKSPACE: begin
          if (cursor_col != '0) begin
            cursor_col <= cursor_col - tcce_pkg::COL_W'(1);
          end else if (cursor_row != '0) begin
            cursor_row <= cursor_row - tcce_pkg::ROW_W'(1);
            cursor_col <= text_columns - tcce_pkg::COL_W'(1);
          end
        end
        tcce_pkg::A_CLEAR: begin
          cursor_col  <= '0;
          cursor_row  <= '0;
          flushed_col <= '0;
          flushed_row <= '0;
        end
        tcce_pkg::A_EMIT_FLUSH: begin
          if (!stall) begin
            flushed_col <= cursor_col;
            flushed_row <= cursor_row;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      char_q <= (char_code == tcce_pkg::CHAR_TAB) ? tcce_pkg::CHAR_SPACE : char_code;
      fg_q   <= (draw_color != '0) ? draw_color : default_fg;
      if (opcode == tcce_pkg::OP_PUT && char_code == tcce_pkg::CHAR_TAB) begin
        cnt_q <= tab_count;
      end else begin
        cnt_q <= tcce_pkg::CNT_W'(1);
      end
    end else if (cw.act == tcce_pkg::A_EMIT_DRAW && !stall) begin
      cnt_q <= cnt_q - tcce_pkg::CNT_W'(1);
    end
    if (cw.act == tcce_pkg::A_SCROLL_CHK) scr_q <= (cursor_row >= text_rows);
    if (cw.act == tcce_pkg::A_ROW_BYTES) begin
      rb_q <= tcce_pkg::RB_W'(ghc_prod)
            * tcce_pkg::RB_W'(tcce_pkg::GLYPH_WIDTH * tcce_pkg::BYTES_PER_PIXEL);
    end
    if (cw.act == tcce_pkg::A_REGION_START) rs_q <= mul_sat;
    if (cw.act == tcce_pkg::A_REGION_END)   re_q <= mul_sat;
  end

  // command contents for each command step
  always_comb begin
    cmd_d   = tcce_pkg::CMD_DRAW;
    col_d   = '0;
    row_d   = '0;
    glyph_d = '0;
    fg_d    = '0;
    bg_d    = '0;
    bold_d  = 1'b0;
    scr_d   = 1'b0;
    rs_d    = '0;
    re_d    = '0;
    case (cw.act)
      tcce_pkg::A_EMIT_DRAW: begin
        cmd_d   = tcce_pkg::CMD_DRAW;
        col_d   = cursor_col[7:0];
        row_d   = cursor_row[6:0];
        glyph_d = char_q;
        fg_d    = fg_q;
        bg_d    = background;
        bold_d  = bold_font;
        scr_d   = scr_q;
      end
      tcce_pkg::A_EMIT_SCROLL:   cmd_d = tcce_pkg::CMD_SCROLL;
      tcce_pkg::A_EMIT_CLR_CELL: begin
        cmd_d = tcce_pkg::CMD_CLEAR_CELL;
        col_d = cursor_col[7:0];
        row_d = cursor_row[6:0];
        bg_d  = background;
      end
      tcce_pkg::A_EMIT_CLS:      cmd_d = tcce_pkg::CMD_CLEAR_SCREEN;
      tcce_pkg::A_EMIT_FLUSH: begin
        cmd_d = tcce_pkg::CMD_FLUSH;
        rs_d  = rs_q;
        re_d  = re_q;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      command       <= cmd_d;
      cell_col      <= col_d;
      cell_row      <= row_d;
      glyph_code    <= glyph_d;
      fg_out        <= fg_d;
      bg_out        <= bg_d;
      bold_out      <= bold_d;
      scroll_before <= scr_d;
      region_start  <= rs_d;
      region_end    <= re_d;
      last          <= (cw.act == tcce_pkg::A_EMIT_DRAW) ? is_last : 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcce_checker.sv =====
// tcce_checker: port-level assertions for the text cursor engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tcce_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  command,
  input wire logic [7:0]  glyph_code,
  input wire logic [31:0] fg_out,
  input wire logic        scroll_before,
  input wire logic        last
);

  // a stalled command stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output command dropped while stalled");

  // no command is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // while a tab is still expanding no new transaction is taken
  a_busy_mid_tab: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken before all commands of a transaction were issued");

  // only draws carry glyph, foreground or a pending scroll
  a_draw_only_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != tcce_pkg::CMD_DRAW |->
      glyph_code == '0 && fg_out == '0 && !scroll_before)
    else $error("draw fields set on a non-draw command");

  // commands other than draws are single and final
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != tcce_pkg::CMD_DRAW |-> last)
    else $error("non-draw command not marked last");

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for the text console cursor engine, predicted commands vs. dut
`timescale 1ns / 1ps

module tb;

  // opcodes the block has no routine for
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES = 64;    // longest routine is a full tab
  localparam int HOLD_AT       = 60;    // command count at which the sink backs off
  localparam int HOLD_CYCLES   = 400;
  localparam int SIDE_SEND     = 0;
  localparam int SIDE_RECV     = 1;
  localparam longint unsigned FLUSH_CAP = 64'd16777216;

  // one command on the output channel
  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  cell_col;
    logic [6:0]  cell_row;
    logic [7:0]  glyph_code;
    logic [31:0] fg_out;
    logic [31:0] bg_out;
    logic        bold_out;
    logic        scroll_before;
    logic [24:0] region_start;
    logic [24:0] region_end;
    logic        last;
  } console_cmd_t;

  // one row of the directed table; typed rows carry their single command, or none
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  ch;
    logic [31:0] color;
    logic        shrink;
    logic        typed;
    logic        n_exp;
    logic [2:0]  cmd;
    logic [7:0]  col;
    logic [6:0]  row;
    logic [7:0]  glyph;
    logic [31:0] fg;
  } dir_row_t;

  localparam int DIR_N = 25;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  opcode;
  logic [7:0]  char_code;
  logic [31:0] draw_color;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  command;
  logic [7:0]  cell_col;
  logic [6:0]  cell_row;
  logic [7:0]  glyph_code;
  logic [31:0] fg_out;
  logic [31:0] bg_out;
  logic        bold_out;
  logic        scroll_before;
  logic [24:0] region_start;
  logic [24:0] region_end;
  logic        last;

  text_console_cursor_engine_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .char_code(char_code), .draw_color(draw_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .command(command), .cell_col(cell_col), .cell_row(cell_row),
    .glyph_code(glyph_code), .fg_out(fg_out), .bg_out(bg_out),
    .bold_out(bold_out), .scroll_before(scroll_before),
    .region_start(region_start), .region_end(region_end), .last(last)
  );

  // shadow of the configuration registers
  logic [8:0]  sh_cols;
  logic [7:0]  sh_rows;
  logic [5:0]  sh_gh;
  logic [31:0] sh_fg;
  logic [31:0] sh_bg;
  logic        sh_bold;
  logic        sh_render;

  // predicted cursor state
  logic [8:0]  cur_col;
  logic [7:0]  cur_row;
  logic [8:0]  fl_col;
  logic [7:0]  fl_row;

  console_cmd_t step_cmds[$];      // commands of the operation being predicted
  console_cmd_t pending_cmds[$];   // commands still owed by the dut
  int mismatches;
  int results_seen;
  int stretch_left [2];
  bit stretch_calm [2];

  dir_row_t dir_tab [0:DIR_N-1] = '{
    // empty operations right after reset
    '{tcce_pkg::OP_BACK, 8'h00, 32'h0, 1'b0, 1'b1, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_REFRESH, 8'h00, 32'h0, 1'b0, 1'b1, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{OP_SPARE_LO, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{OP_SPARE_HI, 8'h00, 32'h0, 1'b0, 1'b1, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    // plain glyphs, default and extreme colors
    '{tcce_pkg::OP_PUT, 8'h41, 32'h0, 1'b0, 1'b1, 1'b1,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h41, 32'h00FF_FFFF},
    '{tcce_pkg::OP_PUT, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1,
      tcce_pkg::CMD_DRAW, 8'd1, 7'd0, 8'hFF, 32'hFFFF_FFFF},
    '{tcce_pkg::OP_PUT, 8'h00, 32'h1, 1'b0, 1'b1, 1'b1,
      tcce_pkg::CMD_DRAW, 8'd2, 7'd0, 8'h00, 32'h1},
    // partial tab, then a full eight-space tab
    '{tcce_pkg::OP_PUT, tcce_pkg::CHAR_TAB, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_PUT, tcce_pkg::CHAR_TAB, 32'h8000_0000, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_BACK, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_REFRESH, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    // newline by character and by opcode, no scroll yet
    '{tcce_pkg::OP_PUT, tcce_pkg::CHAR_LF, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_NEWLINE, 8'h5A, 32'h1234_5678, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    // backspace from column zero lands on the last column of the row above
    '{tcce_pkg::OP_BACK, 8'h00, 32'h0, 1'b0, 1'b1, 1'b1,
      tcce_pkg::CMD_CLEAR_CELL, 8'd127, 7'd1, 8'h00, 32'h0},
    '{tcce_pkg::OP_NEWLINE, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_NEWLINE, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    // tiny screen with the cursor below it: single step back, wraps and scrolls
    '{tcce_pkg::OP_PUT, 8'h7A, 32'h0, 1'b1, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_PUT, 8'h79, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_PUT, tcce_pkg::CHAR_TAB, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_NEWLINE, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_REFRESH, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_BACK, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    // clear, then empty operations at the origin again
    '{tcce_pkg::OP_CLEAR, 8'h00, 32'h0, 1'b0, 1'b1, 1'b1,
      tcce_pkg::CMD_CLEAR_SCREEN, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_BACK, 8'h00, 32'h0, 1'b0, 1'b1, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0},
    '{tcce_pkg::OP_REFRESH, 8'h00, 32'h0, 1'b0, 1'b1, 1'b0,
      tcce_pkg::CMD_DRAW, 8'd0, 7'd0, 8'h00, 32'h0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // idle gap for one transaction, in stretches that are either calm or busy
  function automatic int draw_gap(input int side);
    if (stretch_left[side] == 0) begin
      stretch_calm[side] = ($urandom_range(0, 3) == 0);
      stretch_left[side] = int'($urandom_range(5, 25));
    end
    stretch_left[side]--;
    return stretch_calm[side] ? 0 : int'($urandom_range(0, 10));
  endfunction

  // ---------------------------------------------------------------- predictor

  // queue one command unless rendering is off or the operation is full
  task automatic stage_cmd(input logic [2:0] cmd, input logic [8:0] col, input logic [7:0] row,
                           input logic [7:0] glyph, input logic [31:0] fg,
                           input logic [31:0] bg, input logic bold, input logic scr,
                           input longint unsigned rs, input longint unsigned re);
    console_cmd_t c;
    if (!sh_render || step_cmds.size() >= tcce_pkg::MAX_RESULTS) return;
    c.command       = cmd;
    c.cell_col      = col[7:0];
    c.cell_row      = row[6:0];
    c.glyph_code    = glyph;
    c.fg_out        = fg;
    c.bg_out        = bg;
    c.bold_out      = bold;
    c.scroll_before = scr;
    c.region_start  = rs[24:0];
    c.region_end    = re[24:0];
    c.last          = 1'b0;
    step_cmds.push_back(c);
  endtask

  // cursor past the bottom: step back one row and drop the flushed cursor
  function automatic logic step_scroll();
    if (cur_row >= sh_rows) begin
      fl_col  = '0;
      fl_row  = '0;
      cur_col = '0;
      cur_row = cur_row - 8'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic feed_line();
    cur_col = '0;
    cur_row = cur_row + 8'd1;
    if (step_scroll())
      stage_cmd(tcce_pkg::CMD_SCROLL, 9'd0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                64'd0, 64'd0);
  endtask

  task automatic place_glyph(input logic [31:0] fg, input logic [7:0] ch);
    logic scr;
    if (cur_col >= sh_cols) begin
      cur_col = '0;
      cur_row = cur_row + 8'd1;
    end
    scr = step_scroll();
    stage_cmd(tcce_pkg::CMD_DRAW, cur_col, cur_row, ch, fg, sh_bg, sh_bold, scr,
              64'd0, 64'd0);
    cur_col = cur_col + 9'd1;
  endtask

  // work out the commands of one accepted operation into step_cmds
  task automatic console_step(input logic [2:0] op, input logic [7:0] ch,
                              input logic [31:0] color);
    logic [31:0] fg;
    int n;
    longint unsigned rb, rs, re;
    console_cmd_t c;
    step_cmds.delete();
    case (op)
      tcce_pkg::OP_PUT: begin
        fg = (color != 32'd0) ? color : sh_fg;
        if (ch == tcce_pkg::CHAR_LF) begin
          feed_line();
        end else if (ch == tcce_pkg::CHAR_TAB) begin
          n = tcce_pkg::TAB_STOP - (int'(cur_col) % tcce_pkg::TAB_STOP);
          if (n > tcce_pkg::MAX_RESULTS) n = tcce_pkg::MAX_RESULTS;
          for (int i = 0; i < n; i++) place_glyph(fg, tcce_pkg::CHAR_SPACE);
        end else begin
          place_glyph(fg, ch);
        end
      end
      tcce_pkg::OP_BACK: begin
        if (cur_col != 9'd0) begin
          cur_col = cur_col - 9'd1;
          stage_cmd(tcce_pkg::CMD_CLEAR_CELL, cur_col, cur_row, 8'd0, 32'd0, sh_bg,
                    1'b0, 1'b0, 64'd0, 64'd0);
        end else if (cur_row != 8'd0) begin
          cur_row = cur_row - 8'd1;
          cur_col = sh_cols - 9'd1;
          stage_cmd(tcce_pkg::CMD_CLEAR_CELL, cur_col, cur_row, 8'd0, 32'd0, sh_bg,
                    1'b0, 1'b0, 64'd0, 64'd0);
        end
      end
      tcce_pkg::OP_NEWLINE: feed_line();
      tcce_pkg::OP_CLEAR: begin
        cur_col = '0;
        cur_row = '0;
        fl_col  = '0;
        fl_row  = '0;
        stage_cmd(tcce_pkg::CMD_CLEAR_SCREEN, 9'd0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                  64'd0, 64'd0);
      end
      tcce_pkg::OP_REFRESH: begin
        if (fl_row != cur_row || fl_col != cur_col) begin
          rb = 64'(sh_gh);
          rb = rb * 64'(tcce_pkg::GLYPH_WIDTH) * 64'(sh_cols)
             * 64'(tcce_pkg::BYTES_PER_PIXEL);
          rs = 64'(fl_row);
          rs = rs * rb;
          re = 64'(cur_row);
          re = (re + 64'd1) * rb;
          if (rs > FLUSH_CAP) rs = FLUSH_CAP;
          if (re > FLUSH_CAP) re = FLUSH_CAP;
          stage_cmd(tcce_pkg::CMD_FLUSH, 9'd0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                    rs, re);
          fl_row = cur_row;
          fl_col = cur_col;
        end
      end
      default: ;
    endcase
    // flag the final command of the operation
    if (step_cmds.size() > 0) begin
      c = step_cmds.pop_back();
      c.last = 1'b1;
      step_cmds.push_back(c);
    end
  endtask

  // ------------------------------------------------------------- input side

  // offer one transaction and record what it owes once accepted
  task automatic drive_op(input logic [2:0] op, input logic [7:0] ch, input logic [31:0] color,
                          input logic typed, input logic n_exp, input console_cmd_t typed_cmd);
    int gap;
    gap = draw_gap(SIDE_SEND);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    draw_color <= color;
    do @(posedge clk); while (!in_ready);
    console_step(op, ch, color);
    if (typed) begin
      if (n_exp) pending_cmds.push_back(typed_cmd);
    end else begin
      while (step_cmds.size() > 0) pending_cmds.push_back(step_cmds.pop_front());
    end
  endtask

  // stop offering, wait out every owed command and the tail of the routine
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      tcce_pkg::REG_COLUMNS:    sh_cols   = val[8:0];
      tcce_pkg::REG_ROWS:       sh_rows   = val[7:0];
      tcce_pkg::REG_GLYPH_H:    sh_gh     = val[5:0];
      tcce_pkg::REG_DEFAULT_FG: sh_fg     = val;
      tcce_pkg::REG_BACKGROUND: sh_bg     = val;
      tcce_pkg::REG_BOLD:       sh_bold   = val[0];
      tcce_pkg::REG_RENDER:     sh_render = val[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input int cols, input int rows, input int gh,
                                input logic [31:0] fg, input logic [31:0] bg,
                                input logic bold, input logic render);
    settle();
    write_reg(tcce_pkg::REG_COLUMNS, 32'(cols));
    write_reg(tcce_pkg::REG_ROWS, 32'(rows));
    write_reg(tcce_pkg::REG_GLYPH_H, 32'(gh));
    write_reg(tcce_pkg::REG_DEFAULT_FG, fg);
    write_reg(tcce_pkg::REG_BACKGROUND, bg);
    write_reg(tcce_pkg::REG_BOLD, 32'(bold));
    write_reg(tcce_pkg::REG_RENDER, 32'(render));
    end_writes();
  endtask

  // random operations, mostly characters with a mix of edits and refreshes
  task automatic run_random(input int n);
    logic [2:0]  op;
    logic [7:0]  ch;
    logic [31:0] color;
    int r;
    for (int k = 0; k < n; k++) begin
      r  = int'($urandom_range(0, 99));
      ch = 8'($urandom_range(0, 255));
      if (r < 50) begin
        op = tcce_pkg::OP_PUT;
        case ($urandom_range(0, 9))
          0: ch = tcce_pkg::CHAR_TAB;
          1: ch = tcce_pkg::CHAR_LF;
          default: ;
        endcase
      end else if (r < 62) op = tcce_pkg::OP_BACK;
      else if (r < 72) op = tcce_pkg::OP_NEWLINE;
      else if (r < 84) op = tcce_pkg::OP_REFRESH;
      else if (r < 88) op = tcce_pkg::OP_CLEAR;
      else if (r < 92) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else op = tcce_pkg::OP_PUT;
      case ($urandom_range(0, 3))
        0: color = 32'd0;
        1: color = 32'hFFFF_FFFF;
        default: color = $urandom;
      endcase
      drive_op(op, ch, color, 1'b0, 1'b0, '0);
    end
  endtask

  // ------------------------------------------------------------ output side

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // sink: random back-pressure, one long hold-off, field-by-field check
  initial begin : cmd_sink
    int gap;
    console_cmd_t e;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(SIDE_RECV);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_cmds.size() == 0) begin
        $error("command %0d with no transaction owing it", command);
        mismatches++;
      end else begin
        e = pending_cmds.pop_front();
        cmp_field("command", 32'(e.command), 32'(command));
        cmp_field("cell_col", 32'(e.cell_col), 32'(cell_col));
        cmp_field("cell_row", 32'(e.cell_row), 32'(cell_row));
        cmp_field("glyph_code", 32'(e.glyph_code), 32'(glyph_code));
        cmp_field("fg_out", e.fg_out, fg_out);
        cmp_field("bg_out", e.bg_out, bg_out);
        cmp_field("bold_out", 32'(e.bold_out), 32'(bold_out));
        cmp_field("scroll_before", 32'(e.scroll_before), 32'(scroll_before));
        cmp_field("region_start", 32'(e.region_start), 32'(region_start));
        cmp_field("region_end", 32'(e.region_end), 32'(region_end));
        cmp_field("last", 32'(e.last), 32'(last));
      end
    end
  end

  // ---------------------------------------------------------------- main flow
  initial begin : main_flow
    dir_row_t     row;
    console_cmd_t c;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = tcce_pkg::REG_COLUMNS;
    cfg_data   = 32'd0;
    in_valid   = 1'b0;
    opcode     = tcce_pkg::OP_PUT;
    char_code  = 8'd0;
    draw_color = 32'd0;
    mismatches   = 0;
    results_seen = 0;
    stretch_left = '{0, 0};
    stretch_calm = '{1'b0, 1'b0};
    // register and cursor state after reset
    sh_cols   = 9'd128;
    sh_rows   = 8'd48;
    sh_gh     = 6'd16;
    sh_fg     = 32'h00FF_FFFF;
    sh_bg     = 32'd0;
    sh_bold   = 1'b0;
    sh_render = 1'b1;
    cur_col   = '0;
    cur_row   = '0;
    fl_col    = '0;
    fl_row    = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      row = dir_tab[i];
      if (row.shrink) begin
        settle();
        write_reg(tcce_pkg::REG_COLUMNS, 32'd4);
        write_reg(tcce_pkg::REG_ROWS, 32'd2);
        end_writes();
      end
      c = '0;
      c.command    = row.cmd;
      c.cell_col   = row.col;
      c.cell_row   = row.row;
      c.glyph_code = row.glyph;
      c.fg_out     = row.fg;
      c.last       = 1'b1;
      drive_op(row.op, row.ch, row.color, row.typed, row.n_exp, c);
    end

    // default geometry, bold on
    apply_settings(128, 48, 16, $urandom, $urandom, 1'b1, 1'b1);
    run_random(60);

    // narrow short screen: frequent wraps and scrolls
    apply_settings(10, 4, 1, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
    run_random(70);

    // one cell screen: every glyph wraps and scrolls
    apply_settings(1, 1, 32, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1);
    run_random(40);

    // widest, tallest screen: walk far down so both flush offsets saturate
    apply_settings(256, 128, 32, $urandom, $urandom, 1'b0, 1'b1);
    for (int k = 0; k < 70; k++)
      drive_op(($urandom_range(0, 1) != 0) ? tcce_pkg::OP_NEWLINE : tcce_pkg::OP_PUT,
               tcce_pkg::CHAR_LF, $urandom, 1'b0, 1'b0, '0);
    drive_op(tcce_pkg::OP_REFRESH, 8'd0, 32'd0, 1'b0, 1'b0, '0);
    for (int k = 0; k < 5; k++)
      drive_op(tcce_pkg::OP_NEWLINE, 8'd0, 32'd0, 1'b0, 1'b0, '0);
    drive_op(tcce_pkg::OP_REFRESH, 8'd0, 32'd0, 1'b0, 1'b0, '0);
    run_random(10);

    // render off: cursor moves silently
    apply_settings(40, 8, 8, $urandom, $urandom, 1'b1, 1'b0);
    run_random(40);

    // zero columns: backspace from column zero wraps the column register
    apply_settings(0, 6, 5, $urandom, $urandom, 1'b0, 1'b1);
    run_random(30);

    // random geometry
    for (int p = 0; p < 2; p++) begin
      apply_settings(int'($urandom_range(1, 256)), int'($urandom_range(1, 128)),
                     int'($urandom_range(1, 32)), $urandom, $urandom,
                     1'($urandom_range(0, 1)), 1'b1);
      run_random(35);
    end

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
